### sv/assert_macros.svh
// Assertion macros used by the checker module of this block.
// Pure text macros; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in one cycle implies consequent in the next, ignored during reset.
`define APMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle, checked also during reset.
`define APMS_ASSERT_SAME(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

### sv/apms_pkg.sv
// Shared types, constants and helper functions of the ARX plant model block.
// No dependencies; imported by the top level and the port checker.
`default_nettype none

package apms_pkg;

    // Q8.8 sample and Q2.13 coefficient.
    typedef logic signed [15:0] sample_t;
    typedef logic signed [15:0] coef_t;

    localparam sample_t SAMPLE_MIN = 16'sh8000;
    localparam sample_t SAMPLE_MAX = 16'sh7FFF;

    // Coefficient registers pack four taps of 16 bits.
    localparam int COEF_TAPS = 4;
    localparam int TAP_W     = 2;

    // Accumulator of up to eight 32-bit products plus the rounding half.
    localparam int ACC_W      = 36;
    localparam int FRAC_SHIFT = 13;
    localparam int RND_W      = ACC_W - FRAC_SHIFT;
    localparam int RES_W      = RND_W + 1;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = 36'sd4096;

    // Mode register bits.
    localparam int MODE_LIMIT_BIT = 0;
    localparam int MODE_NOISE_BIT = 1;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_MODE       = 3'd0,
        CFG_DELAY      = 3'd1,
        CFG_COEF_B     = 3'd2,
        CFG_COEF_A     = 3'd3,
        CFG_INPUT_MIN  = 3'd4,
        CFG_INPUT_MAX  = 3'd5,
        CFG_OUTPUT_MIN = 3'd6,
        CFG_OUTPUT_MAX = 3'd7
    } cfg_idx_t;

    // Sample engine sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_ACC,
        ST_DONE
    } eng_state_t;

    // Pick one signed 16-bit tap out of a packed coefficient word.
    function automatic coef_t tap_coef(input logic [63:0] packed_coef,
                                       input logic [TAP_W-1:0] idx);
        coef_t c;
        case (idx)
            2'd0:    c = packed_coef[15:0];
            2'd1:    c = packed_coef[31:16];
            2'd2:    c = packed_coef[47:32];
            default: c = packed_coef[63:48];
        endcase
        return c;
    endfunction

    // Clamp with the max test first, so crossed limits favor max.
    function automatic sample_t clamp16(input sample_t x, input sample_t lo,
                                        input sample_t hi);
        sample_t r;
        if (x > hi)
        begin
            r = hi;
        end
        else if (x < lo)
        begin
            r = lo;
        end
        else
        begin
            r = x;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/arx_plant_model_step.sv
// ARX plant model, one sample per transfer.
// Input channel: in_valid / in_stall carry u_in and noise_sample. One input
// transfer is buffered while the engine works on the previous sample, so
// in_stall rises after each transfer and falls when the engine takes it.
// Output channel: out_valid / out_stall carry y_out and limited, one result
// per input, in order. The result sits in an output register; the engine
// only waits when that register is full and stalled at the end of a sample.
// The engine runs through its MAC, ACC and DONE states from taking a sample
// out of the input buffer to loading the result register.
// Only one sample at a time is in the engine, as set by the single shared 16x16
// multiplier that does one b or a tap per cycle, and by the output
// feedback that makes each sample need the previous result.
// Configuration: cfg_we / cfg_index / cfg_data write one register per cycle.
// The user must write only while no sample is in flight (not enforced).
// Reset: rst_n clears all histories, the delay line valid bits, the delay
// pointer and both handshakes; no clearing pass is needed.
// Depends on apms_pkg and apms_ram.
`default_nettype none

module arx_plant_model_step
    import apms_pkg::*;
#(
    parameter int NUM_TAPS  = 4,
    parameter int MAX_DELAY = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire sample_t     u_in,
    input  wire sample_t     noise_sample,
    // Output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output sample_t          y_out,
    output logic             limited,
    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    localparam int PW     = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int SW     = $clog2(2 * NUM_TAPS) > 0 ? $clog2(2 * NUM_TAPS) : 1;
    localparam int DMAX_W = 9;

    // Configuration registers.
    logic [1:0]  mode_reg;
    logic [3:0]  delay_reg;
    logic [63:0] coef_b_reg;
    logic [63:0] coef_a_reg;
    sample_t     in_min_reg;
    sample_t     in_max_reg;
    sample_t     out_min_reg;
    sample_t     out_max_reg;

    // Input buffer.
    logic    buf_valid_reg;
    sample_t buf_u_reg;
    sample_t buf_noise_reg;

    // Engine state.
    eng_state_t     state_reg;
    eng_state_t     state_next;
    logic [SW-1:0]  step_reg;
    logic [PW-1:0]  ptr_reg;
    logic [MAX_DELAY-1:0] dl_vld_reg;
    sample_t        uc_reg;
    sample_t        noise_reg;
    logic           fwd_reg;
    logic           rd_vld_reg;
    sample_t        in_hist_reg  [NUM_TAPS];
    sample_t        out_hist_reg [NUM_TAPS];
    sample_t        in_hist_next [NUM_TAPS];
    sample_t        out_hist_next[NUM_TAPS];

    // Multiply-accumulate pipeline.
    logic signed [31:0]      prod_reg;
    logic                    prod_sub_reg;
    logic                    prod_vld_reg;
    logic signed [ACC_W-1:0] acc_reg;

    // Output register.
    logic    out_valid_reg;
    sample_t y_reg;
    logic    lim_reg;

    // Control.
    logic    out_free;
    logic    start;
    logic    finish;
    logic    mac_en;
    logic    lim_on;
    logic    noise_on;

    // Delay line access.
    logic [PW-1:0]     d_eff;
    logic [PW-1:0]     rd_addr;
    logic [PW:0]       rd_wrap;
    logic [PW-1:0]     ptr_inc;
    sample_t           u_clamped;
    logic [15:0]       ram_rdata;
    sample_t           ud_now;

    // Tap selection.
    logic              is_a;
    logic [TAP_W-1:0]  tap_idx;
    coef_t             mul_coef;
    sample_t           mul_sample;

    // Result path.
    logic signed [RND_W-1:0] y_rnd;
    logic signed [RES_W-1:0] y_sum;
    logic signed [RES_W-1:0] y_lim;
    logic                    lim_flag;
    sample_t                 y_final;
    logic                    res_limited;

    assign lim_on   = mode_reg[MODE_LIMIT_BIT];
    assign noise_on = mode_reg[MODE_NOISE_BIT];

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= '0;
            delay_reg   <= '0;
            coef_b_reg  <= '0;
            coef_a_reg  <= '0;
            in_min_reg  <= SAMPLE_MIN;
            in_max_reg  <= SAMPLE_MAX;
            out_min_reg <= SAMPLE_MIN;
            out_max_reg <= SAMPLE_MAX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MODE:       mode_reg    <= cfg_data[1:0];
                CFG_DELAY:      delay_reg   <= cfg_data[3:0];
                CFG_COEF_B:     coef_b_reg  <= cfg_data;
                CFG_COEF_A:     coef_a_reg  <= cfg_data;
                CFG_INPUT_MIN:  in_min_reg  <= cfg_data[15:0];
                CFG_INPUT_MAX:  in_max_reg  <= cfg_data[15:0];
                CFG_OUTPUT_MIN: out_min_reg <= cfg_data[15:0];
                CFG_OUTPUT_MAX: out_max_reg <= cfg_data[15:0];
                default:        mode_reg    <= mode_reg;
            endcase
        end
    end

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (buf_valid_reg)
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (step_reg == SW'(2 * NUM_TAPS - 1))
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = buf_valid_reg ? ST_MAC : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer: outputs.
    always_comb
    begin
        start  = 1'b0;
        finish = 1'b0;
        mac_en = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                start = buf_valid_reg;
            end
            ST_MAC:
            begin
                mac_en = 1'b1;
            end
            ST_ACC:
            begin
                mac_en = 1'b0;
            end
            ST_DONE:
            begin
                finish = out_free;
                start  = out_free && buf_valid_reg;
            end
            default:
            begin
                mac_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Input buffer: filled by a transfer, emptied when the engine starts.
    assign in_stall = buf_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
        end
        else if (in_valid && !buf_valid_reg)
        begin
            buf_valid_reg <= 1'b1;
        end
        else if (start)
        begin
            buf_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !buf_valid_reg)
        begin
            buf_u_reg     <= u_in;
            buf_noise_reg <= noise_sample;
        end
    end

    // Delay line addressing; the delay saturates to the line length minus one.
    assign u_clamped = lim_on ? clamp16(buf_u_reg, in_min_reg, in_max_reg) : buf_u_reg;
    assign d_eff     = (DMAX_W'(delay_reg) > DMAX_W'(MAX_DELAY - 1)) ?
                       PW'(MAX_DELAY - 1) : PW'(delay_reg);
    assign rd_wrap   = {1'b0, ptr_reg} + (PW + 1)'(MAX_DELAY) - {1'b0, d_eff};
    assign rd_addr   = (ptr_reg >= d_eff) ? (ptr_reg - d_eff) : rd_wrap[PW-1:0];
    assign ptr_inc   = (ptr_reg == PW'(MAX_DELAY - 1)) ? '0 : ptr_reg + 1'b1;

    apms_ram #(
        .WIDTH (16),
        .DEPTH (MAX_DELAY),
        .AW    (PW)
    ) u_delay_ram (
        .clk   (clk),
        .we    (start),
        .waddr (ptr_reg),
        .wdata (u_clamped),
        .re    (start),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Never-written entries read as zero; a zero delay forwards the new sample.
    assign ud_now = fwd_reg ? uc_reg : (rd_vld_reg ? sample_t'(ram_rdata) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg    <= '0;
            dl_vld_reg <= '0;
            fwd_reg    <= 1'b0;
            rd_vld_reg <= 1'b0;
            step_reg   <= '0;
        end
        else if (start)
        begin
            ptr_reg             <= ptr_inc;
            dl_vld_reg[ptr_reg] <= 1'b1;
            fwd_reg             <= (rd_addr == ptr_reg);
            rd_vld_reg          <= dl_vld_reg[rd_addr];
            step_reg            <= '0;
        end
        else if (mac_en)
        begin
            step_reg <= step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            uc_reg    <= u_clamped;
            noise_reg <= buf_noise_reg;
        end
    end

    // Next histories: input takes the delayed sample, output takes the result.
    always_comb
    begin
        in_hist_next[0]  = ud_now;
        out_hist_next[0] = y_final;
        for (int k = 1; k < NUM_TAPS; k++)
        begin
            in_hist_next[k]  = in_hist_reg[k-1];
            out_hist_next[k] = out_hist_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_TAPS; k++)
            begin
                in_hist_reg[k]  <= '0;
                out_hist_reg[k] <= '0;
            end
        end
        else if (finish)
        begin
            for (int k = 0; k < NUM_TAPS; k++)
            begin
                in_hist_reg[k]  <= in_hist_next[k];
                out_hist_reg[k] <= out_hist_next[k];
            end
        end
    end

    // Tap select: a taps first on the old output history, then b taps on the
    // shifted input history, the newest delayed sample first.
    assign is_a    = (step_reg < SW'(NUM_TAPS));
    assign tap_idx = is_a ? TAP_W'(step_reg) : TAP_W'(step_reg - SW'(NUM_TAPS));
    assign mul_coef = is_a ? tap_coef(coef_a_reg, tap_idx) : tap_coef(coef_b_reg, tap_idx);

    always_comb
    begin
        mul_sample = '0;
        for (int k = 0; k < NUM_TAPS; k++)
        begin
            if (tap_idx == TAP_W'(k))
            begin
                mul_sample = is_a ? out_hist_reg[k] : in_hist_next[k];
            end
        end
    end

    // Shared multiplier, registered product.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= mac_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mac_en)
        begin
            prod_reg     <= 32'(mul_sample) * 32'(mul_coef);
            prod_sub_reg <= is_a;
        end
    end

    // Accumulator, preloaded with the rounding half at the start of a sample.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= ROUND_HALF;
        end
        else if (prod_vld_reg)
        begin
            if (prod_sub_reg)
            begin
                acc_reg <= acc_reg - ACC_W'(prod_reg);
            end
            else
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    // Rounding, noise, output clamp and 16-bit saturation.
    assign y_rnd = acc_reg[ACC_W-1:FRAC_SHIFT];
    assign y_sum = RES_W'(y_rnd) + (noise_on ? RES_W'(noise_reg) : RES_W'(0));

    always_comb
    begin
        y_lim    = y_sum;
        lim_flag = 1'b0;
        if (lim_on)
        begin
            if (y_sum > RES_W'(out_max_reg))
            begin
                y_lim    = RES_W'(out_max_reg);
                lim_flag = 1'b1;
            end
            else if (y_sum < RES_W'(out_min_reg))
            begin
                y_lim    = RES_W'(out_min_reg);
                lim_flag = 1'b1;
            end
        end
        if (y_lim > RES_W'(SAMPLE_MAX))
        begin
            y_final     = SAMPLE_MAX;
            res_limited = 1'b1;
        end
        else if (y_lim < RES_W'(SAMPLE_MIN))
        begin
            y_final     = SAMPLE_MIN;
            res_limited = 1'b1;
        end
        else
        begin
            y_final     = y_lim[15:0];
            res_limited = lim_flag;
        end
    end

    // Output register.
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            y_reg   <= y_final;
            lim_reg <= res_limited;
        end
    end

    assign out_valid = out_valid_reg;
    assign y_out     = y_reg;
    assign limited   = lim_reg;

endmodule

`default_nettype wire

### sv/apms_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; holds the transport delay line of the plant model.
`default_nettype none

module apms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sv/apms_checker.sv
// Port-level checker for the ARX plant model, bound to the top level.
// Depends on apms_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module apms_checker
    import apms_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    in_valid,
    input wire logic    in_stall,
    input wire logic    out_valid,
    input wire logic    out_stall,
    input wire sample_t y_out,
    input wire logic    limited
);

    // A held result keeps its value until the transfer.
    `APMS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(y_out) && $stable(limited), "stalled result changed")

    // The input buffer holds one sample, so a transfer always fills it.
    `APMS_ASSERT_NEXT(a_in_full, clk, rst_n, in_valid && !in_stall, in_stall, "input buffer not full after a transfer")

    // Once reset has been held for a full cycle, neither side shows pending work.
    `APMS_ASSERT_SAME(a_reset_quiet, clk, !rst_n && $past(!rst_n), !out_valid && !in_stall, "handshake active during reset")

endmodule

bind arx_plant_model_step apms_checker u_apms_checker (.*);

`default_nettype wire

### test/arx_plant_model_step_tb.sv
// Self-checking testbench for the ARX plant model block arx_plant_model_step.
// It drives random and directed samples, predicts every output sample with its
// own bit-exact plant model and compares the results. Depends on apms_pkg.
`default_nettype none

module arx_plant_model_step_tb;
    import apms_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_PHASES = 14;
    localparam int PHASE_SAMPLES = 125;

    typedef struct {
        sample_t y;
        logic    lim;
    } plant_out_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    sample_t     u_in;
    sample_t     noise_sample;
    logic        out_valid;
    logic        out_stall;
    sample_t     y_out;
    logic        limited;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    // Predicted output samples, oldest first.
    plant_out_t expected_outputs[$];
    int mismatches = 0;

    // Stall and gap control for the sender and the receiver.
    int rx_stall_pct = 0;
    int tx_gap_pct = 0;
    int rx_hold_req = 0;
    int hold_left = 0;
    int stall_left = 0;

    // Plant configuration as the block holds it.
    logic [1:0]  plant_mode;
    logic [3:0]  plant_delay;
    logic [63:0] gain_b;
    logic [63:0] gain_a;
    sample_t     in_lo;
    sample_t     in_hi;
    sample_t     out_lo;
    sample_t     out_hi;

    // Plant state: transport delay line and the two histories, index 0 newest.
    sample_t     delay_mem[16];
    logic [3:0]  delay_wr;
    sample_t     u_hist[4];
    sample_t     y_hist[4];

    arx_plant_model_step dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .u_in         (u_in),
        .noise_sample (noise_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .y_out        (y_out),
        .limited      (limited),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    // Reset values of the plant model.
    initial
    begin
        plant_mode = 2'd0;
        plant_delay = 4'd0;
        gain_b = 64'd0;
        gain_a = 64'd0;
        in_lo = SAMPLE_MIN;
        in_hi = SAMPLE_MAX;
        out_lo = SAMPLE_MIN;
        out_hi = SAMPLE_MAX;
        delay_wr = 4'd0;
        for (int i = 0; i < 16; i++)
        begin
            delay_mem[i] = '0;
        end
        for (int i = 0; i < 4; i++)
        begin
            u_hist[i] = '0;
            y_hist[i] = '0;
        end
    end

    // Gap length: zero unless a gap starts, then mostly short and a few long.
    function automatic int pick_gap(input int pct);
        int r;
        if (pct == 0 || $urandom_range(99) >= pct)
        begin
            return 0;
        end
        r = $urandom_range(99);
        if (r < 80)
        begin
            return $urandom_range(3, 1);
        end
        else if (r < 96)
        begin
            return $urandom_range(12, 4);
        end
        return $urandom_range(60, 20);
    endfunction

    // Sample values weighted toward the extremes and small magnitudes.
    function automatic sample_t pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 5)
        begin
            return SAMPLE_MAX;
        end
        else if (r < 10)
        begin
            return SAMPLE_MIN;
        end
        else if (r < 13)
        begin
            return sample_t'(0);
        end
        else if (r < 15)
        begin
            return sample_t'(-1);
        end
        else if (r < 40)
        begin
            return sample_t'(int'($urandom_range(512)) - 256);
        end
        return sample_t'($urandom);
    endfunction

    // Four packed Q2.13 taps: mostly within +-span, some zero, some anything.
    function automatic logic [63:0] random_taps(input int span);
        logic [63:0] w;
        int r;
        int t;
        w = '0;
        for (int i = 0; i < 4; i++)
        begin
            r = $urandom_range(9);
            if (r < 2)
            begin
                t = 0;
            end
            else if (r < 8)
            begin
                t = int'($urandom_range(2 * span)) - span;
            end
            else
            begin
                t = int'($urandom);
            end
            w[16*i +: 16] = 16'(t);
        end
        return w;
    endfunction

    // Input clamp: the upper bound is tested first, so crossed limits favor it.
    function automatic sample_t limit_sample(input sample_t x, input sample_t lo,
                                             input sample_t hi);
        if (x > hi)
        begin
            return hi;
        end
        else if (x < lo)
        begin
            return lo;
        end
        return x;
    endfunction

    // Advance the plant model by one sample and return the predicted output.
    task automatic advance_plant(input sample_t u, input sample_t n,
                                 output plant_out_t res);
        sample_t    uc;
        sample_t    ud;
        logic [3:0] rd;
        longint     acc;
        longint     y;
        longint     yc;
        coef_t      cb;
        coef_t      ca;
        logic       lim;
        uc = plant_mode[MODE_LIMIT_BIT] ? limit_sample(u, in_lo, in_hi) : u;
        delay_mem[delay_wr] = uc;
        rd = delay_wr - plant_delay;
        ud = delay_mem[rd];
        delay_wr = delay_wr + 4'd1;
        for (int i = 3; i > 0; i--)
        begin
            u_hist[i] = u_hist[i-1];
        end
        u_hist[0] = ud;
        acc = 0;
        for (int i = 0; i < 4; i++)
        begin
            cb = gain_b[16*i +: 16];
            ca = gain_a[16*i +: 16];
            acc += longint'(u_hist[i]) * longint'(cb);
            acc -= longint'(y_hist[i]) * longint'(ca);
        end
        // Round to nearest Q8.8 with ties toward plus infinity.
        y = (acc + 64'sd4096) >>> 13;
        if (plant_mode[MODE_NOISE_BIT])
        begin
            y += longint'(n);
        end
        lim = 1'b0;
        if (plant_mode[MODE_LIMIT_BIT])
        begin
            if (y > longint'(out_hi))
            begin
                y = longint'(out_hi);
                lim = 1'b1;
            end
            else if (y < longint'(out_lo))
            begin
                y = longint'(out_lo);
                lim = 1'b1;
            end
        end
        yc = y;
        if (yc > 32767)
        begin
            yc = 32767;
        end
        else if (yc < -32768)
        begin
            yc = -32768;
        end
        if (yc != y)
        begin
            lim = 1'b1;
        end
        for (int i = 3; i > 0; i--)
        begin
            y_hist[i] = y_hist[i-1];
        end
        y_hist[0] = sample_t'(yc);
        res.y = sample_t'(yc);
        res.lim = lim;
    endtask

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("mismatch %0d at %0t: %s", mismatches, $realtime, msg);
        end
    endtask

    // One register write; the write enable stays high for a following write.
    task automatic cfg_write(input cfg_idx_t idx, input logic [63:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            CFG_MODE:       plant_mode = data[1:0];
            CFG_DELAY:      plant_delay = data[3:0];
            CFG_COEF_B:     gain_b = data;
            CFG_COEF_A:     gain_a = data;
            CFG_INPUT_MIN:  in_lo = data[15:0];
            CFG_INPUT_MAX:  in_hi = data[15:0];
            CFG_OUTPUT_MIN: out_lo = data[15:0];
            CFG_OUTPUT_MAX: out_hi = data[15:0];
            default:        ;
        endcase
    endtask

    // Write every register, then release the write enable.
    task automatic load_config(input logic [1:0] mode, input logic [3:0] dly,
                               input logic [63:0] b, input logic [63:0] a,
                               input sample_t ilo, input sample_t ihi,
                               input sample_t olo, input sample_t ohi);
        cfg_write(CFG_MODE, {62'd0, mode});
        cfg_write(CFG_DELAY, {60'd0, dly});
        cfg_write(CFG_COEF_B, b);
        cfg_write(CFG_COEF_A, a);
        cfg_write(CFG_INPUT_MIN, {{48{ilo[15]}}, ilo});
        cfg_write(CFG_INPUT_MAX, {{48{ihi[15]}}, ihi});
        cfg_write(CFG_OUTPUT_MIN, {{48{olo[15]}}, olo});
        cfg_write(CFG_OUTPUT_MAX, {{48{ohi[15]}}, ohi});
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Offer one sample and wait for its transfer, then record the prediction.
    task automatic send_sample(input sample_t u, input sample_t n);
        plant_out_t want;
        @(negedge clk);
        in_valid <= 1'b1;
        u_in <= u;
        noise_sample <= n;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        advance_plant(u, n, want);
        expected_outputs.push_back(want);
    endtask

    task automatic send_with_gap(input sample_t u, input sample_t n);
        int gap;
        gap = pick_gap(tx_gap_pct);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        send_sample(u, n);
    endtask

    // Stop offering and wait until every predicted output has been received.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_outputs.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Limit pair: the full range, any order, or ordered.
    task automatic pick_limits(output sample_t lo, output sample_t hi);
        int r;
        sample_t p;
        sample_t q;
        r = $urandom_range(9);
        p = sample_t'($urandom);
        q = sample_t'($urandom);
        if (r < 2)
        begin
            lo = SAMPLE_MIN;
            hi = SAMPLE_MAX;
        end
        else if (r < 4)
        begin
            lo = p;
            hi = q;
        end
        else
        begin
            lo = (p < q) ? p : q;
            hi = (p < q) ? q : p;
        end
    endtask

    task automatic random_config(input int phase);
        logic [3:0] dly;
        sample_t ilo;
        sample_t ihi;
        sample_t olo;
        sample_t ohi;
        case (phase % 3)
            0:       dly = 4'd0;
            1:       dly = 4'd15;
            default: dly = 4'($urandom_range(15));
        endcase
        pick_limits(ilo, ihi);
        pick_limits(olo, ohi);
        load_config(2'(phase % 4), dly, random_taps(8192), random_taps(3072),
                    ilo, ihi, olo, ohi);
    endtask

    // With the reset configuration all coefficients are zero.
    task automatic test_reset_state();
        send_sample(SAMPLE_MAX, SAMPLE_MAX);
        send_sample(SAMPLE_MIN, SAMPLE_MIN);
        wait_drained();
    endtask

    // Unity gain passes extremes through; half gain shows the rounding of ties.
    task automatic test_unity_gain();
        load_config(2'd0, 4'd0, 64'h0000_0000_0000_2000, 64'd0,
                    SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
        send_sample(SAMPLE_MAX, 16'sd0);
        send_sample(SAMPLE_MIN, 16'sd0);
        send_sample(16'sd0, 16'sd0);
        wait_drained();
        load_config(2'd0, 4'd0, 64'h0000_0000_0000_1000, 64'd0,
                    SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
        send_sample(16'sd1, 16'sd0);
        send_sample(-16'sd1, 16'sd0);
        send_sample(16'sd3, 16'sd0);
        wait_drained();
    endtask

    // Large gain and noise push the output past 16 bits in both directions.
    task automatic test_noise_saturation();
        load_config(2'd2, 4'd0, 64'h0000_0000_0000_7FFF, 64'd0,
                    SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
        send_sample(SAMPLE_MAX, SAMPLE_MAX);
        send_sample(SAMPLE_MIN, SAMPLE_MIN);
        send_sample(16'sd0, 16'sh5A5A);
        send_sample(16'sd16, -16'sd1);
        wait_drained();
    endtask

    // Input and output clamps, then crossed limits where the maximum wins.
    task automatic test_limits();
        load_config(2'd1, 4'd0, 64'h0000_0000_0000_2000, 64'd0,
                    -16'sd256, 16'sd256, -16'sd128, 16'sd128);
        send_sample(16'sd1000, 16'sd0);
        send_sample(-16'sd1000, 16'sd0);
        send_sample(16'sd50, 16'sd0);
        wait_drained();
        load_config(2'd1, 4'd0, 64'h0000_0000_0000_2000, 64'd0,
                    16'sd100, -16'sd100, 16'sd50, -16'sd50);
        send_sample(16'sd0, 16'sd0);
        send_sample(-16'sd200, 16'sd0);
        wait_drained();
    endtask

    // Transport delay with output feedback, then a shorter delay without a flush.
    task automatic test_delay();
        load_config(2'd0, 4'd3, 64'h0000_0000_0000_2000, 64'h0000_0000_0000_F000,
                    SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
        send_sample(16'sd256, 16'sd0);
        send_sample(16'sd512, 16'sd0);
        send_sample(-16'sd768, 16'sd0);
        send_sample(16'sd1024, 16'sd0);
        send_sample(16'sd7, 16'sd0);
        wait_drained();
        load_config(2'd0, 4'd1, 64'h0000_0000_0000_2000, 64'h0000_0000_0000_F000,
                    SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
        send_sample(16'sd99, 16'sd0);
        send_sample(-16'sd99, 16'sd0);
        wait_drained();
    endtask

    // The receiver holds off while samples keep coming, then both sides pause.
    task automatic test_backpressure();
        random_config(2);
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        rx_hold_req = HOLD_CYCLES;
        for (int k = 0; k < 24; k++)
        begin
            send_sample(pick_sample(), pick_sample());
        end
        wait_drained();
        tx_gap_pct = 30;
        rx_stall_pct = 30;
        for (int k = 0; k < 16; k++)
        begin
            send_with_gap(pick_sample(), pick_sample());
        end
        wait_drained();
    endtask

    // Random configurations, each followed by a run of random samples.
    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            random_config(phase);
            case (phase % 3)
                0:
                begin
                    tx_gap_pct = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_gap_pct = 20;
                    rx_stall_pct = 20;
                end
                default:
                begin
                    tx_gap_pct = 50;
                    rx_stall_pct = 50;
                end
            endcase
            for (int k = 0; k < PHASE_SAMPLES; k++)
            begin
                send_with_gap(pick_sample(), pick_sample());
            end
            wait_drained();
        end
    endtask

    // Output receiver: requested hold-off first, then random stall runs.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && rx_hold_req != 0)
            begin
                hold_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (stall_left == 0)
            begin
                stall_left = pick_gap(rx_stall_pct);
            end
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (stall_left != 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Compare each output transfer with the oldest prediction.
    always @(posedge clk)
    begin
        plant_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_outputs.size() == 0)
            begin
                note_failure($sformatf("unexpected output y_out=%0d limited=%0b",
                                       y_out, limited));
            end
            else
            begin
                want = expected_outputs.pop_front();
                if (y_out !== want.y)
                begin
                    note_failure($sformatf("y_out expected %0d, got %0d",
                                           want.y, y_out));
                end
                if (limited !== want.lim)
                begin
                    note_failure($sformatf("limited expected %0b, got %0b",
                                           want.lim, limited));
                end
            end
        end
    end

    // Watchdog: ends the run after too many cycles without any transfer.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("timeout after %0d idle cycles", IDLE_LIMIT);
        $display("[arx_plant_model_step] ERROR");
        $finish;
    end

    // Main sequence.
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        u_in = '0;
        noise_sample = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (7)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_unity_gain();
        test_noise_saturation();
        test_limits();
        test_delay();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (12)
        begin
            @(posedge clk);
        end
        if (expected_outputs.size() != 0)
        begin
            note_failure($sformatf("%0d outputs never arrived", expected_outputs.size()));
        end
        if (mismatches == 0)
        begin
            $display("[arx_plant_model_step] OK");
        end
        else
        begin
            $display("[arx_plant_model_step] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
